FILE: hdl/utf8_sequence_decoder_unit_defines.svh
// Assertion macros shared by the UTF-8 sequence decoder RTL.
`ifndef UTF8_SEQUENCE_DECODER_UNIT_DEFINES_SVH
`define UTF8_SEQUENCE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define USD_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("usd: %s failed", "label");

// Next-cycle implication, checked outside reset.
`define USD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("usd: %s failed", "label");

`endif

FILE: hdl/usd_pkg.sv
// Package: types and constants of the UTF-8 sequence decoder.
package usd_pkg;

   localparam int ByteWidth      = 8;
   localparam int CodePointWidth = 31;
   localparam int LengthWidth    = 3;

   // Sequence lengths; zero marks a lead byte that starts no sequence
   localparam logic [LengthWidth-1:0] LenInvalid = 3'd0;
   localparam logic [LengthWidth-1:0] LenOne     = 3'd1;
   localparam logic [LengthWidth-1:0] LenTwo     = 3'd2;
   localparam logic [LengthWidth-1:0] LenThree   = 3'd3;
   localparam logic [LengthWidth-1:0] LenFour    = 3'd4;
   localparam logic [LengthWidth-1:0] LenFive    = 3'd5;
   localparam logic [LengthWidth-1:0] LenSix     = 3'd6;

   localparam logic [CodePointWidth-1:0] ReplacementChar = 31'h0000_FFFD;
   localparam logic [CodePointWidth-1:0] SurrogateLow    = 31'h0000_D800;
   localparam logic [CodePointWidth-1:0] SurrogateHigh   = 31'h0000_DFFF;
   localparam logic [CodePointWidth-1:0] NonCharFffe     = 31'h0000_FFFE;
   localparam logic [CodePointWidth-1:0] NonCharFfff     = 31'h0000_FFFF;

   // Smallest value that legitimately needs each length
   localparam logic [CodePointWidth-1:0] MinLenTwo   = 31'h0000_0080;
   localparam logic [CodePointWidth-1:0] MinLenThree = 31'h0000_0800;
   localparam logic [CodePointWidth-1:0] MinLenFour  = 31'h0001_0000;
   localparam logic [CodePointWidth-1:0] MinLenFive  = 31'h0020_0000;
   localparam logic [CodePointWidth-1:0] MinLenSix   = 31'h0400_0000;

   localparam logic [1:0] ContTag = 2'b10;

   typedef struct packed {
      logic [ByteWidth-1:0] lead_byte;
      logic [ByteWidth-1:0] second_byte;
      logic [ByteWidth-1:0] third_byte;
      logic [ByteWidth-1:0] fourth_byte;
      logic [ByteWidth-1:0] fifth_byte;
      logic [ByteWidth-1:0] sixth_byte;
   } req_payload_type;

   typedef struct packed {
      logic [CodePointWidth-1:0] code_point;
      logic [LengthWidth-1:0]    consumed_length;
   } rsp_payload_type;

endpackage

FILE: hdl/usd_req_if.sv
// Interface: request channel carrying one six-byte window per transaction.
interface usd_req_if;
   logic                          valid;
   logic                          ready;
   logic [usd_pkg::ByteWidth-1:0] lead_byte;
   logic [usd_pkg::ByteWidth-1:0] second_byte;
   logic [usd_pkg::ByteWidth-1:0] third_byte;
   logic [usd_pkg::ByteWidth-1:0] fourth_byte;
   logic [usd_pkg::ByteWidth-1:0] fifth_byte;
   logic [usd_pkg::ByteWidth-1:0] sixth_byte;

   modport source (
      output valid, lead_byte, second_byte, third_byte, fourth_byte, fifth_byte,
             sixth_byte,
      input  ready
   );

   modport sink (
      input  valid, lead_byte, second_byte, third_byte, fourth_byte, fifth_byte,
             sixth_byte,
      output ready
   );
endinterface

FILE: hdl/usd_rsp_if.sv
// Interface: response channel carrying one decoded character per transaction.
interface usd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [usd_pkg::CodePointWidth-1:0] code_point;
   logic [usd_pkg::LengthWidth-1:0]    consumed_length;

   modport source (
      output valid, code_point, consumed_length,
      input  ready
   );

   modport sink (
      input  valid, code_point, consumed_length,
      output ready
   );
endinterface

FILE: hdl/usd_decode.sv
// Combinational decode of one UTF-8 sequence from a six-byte window.
module usd_decode (
   input  usd_pkg::req_payload_type window,
   output usd_pkg::rsp_payload_type result
);

   logic [usd_pkg::LengthWidth-1:0]    seq_len;
   logic [5:1]                         cont;
   logic                               cont_ok;
   logic [usd_pkg::CodePointWidth-1:0] value;
   logic [usd_pkg::CodePointWidth-1:0] min_value;
   logic                               bad_value;

   // Lead byte class
   always_comb begin
      priority if (!window.lead_byte[7]) begin
         seq_len = usd_pkg::LenOne;
      end else if (!window.lead_byte[6]) begin
         seq_len = usd_pkg::LenInvalid;   // stray continuation byte
      end else if (!window.lead_byte[5]) begin
         seq_len = usd_pkg::LenTwo;
      end else if (!window.lead_byte[4]) begin
         seq_len = usd_pkg::LenThree;
      end else if (!window.lead_byte[3]) begin
         seq_len = usd_pkg::LenFour;
      end else if (!window.lead_byte[2]) begin
         seq_len = usd_pkg::LenFive;
      end else if (!window.lead_byte[1]) begin
         seq_len = usd_pkg::LenSix;
      end else begin
         seq_len = usd_pkg::LenInvalid;   // FE / FF
      end
   end

   assign cont[1] = (window.second_byte[7:6] == usd_pkg::ContTag);
   assign cont[2] = (window.third_byte[7:6]  == usd_pkg::ContTag);
   assign cont[3] = (window.fourth_byte[7:6] == usd_pkg::ContTag);
   assign cont[4] = (window.fifth_byte[7:6]  == usd_pkg::ContTag);
   assign cont[5] = (window.sixth_byte[7:6]  == usd_pkg::ContTag);

   // Payload assembly, continuation check and overlong threshold per length
   always_comb begin
      unique case (seq_len)
         usd_pkg::LenTwo: begin
            cont_ok   = cont[1];
            min_value = usd_pkg::MinLenTwo;
            value     = {20'd0, window.lead_byte[4:0], window.second_byte[5:0]};
         end
         usd_pkg::LenThree: begin
            cont_ok   = &cont[2:1];
            min_value = usd_pkg::MinLenThree;
            value     = {15'd0, window.lead_byte[3:0], window.second_byte[5:0],
                         window.third_byte[5:0]};
         end
         usd_pkg::LenFour: begin
            cont_ok   = &cont[3:1];
            min_value = usd_pkg::MinLenFour;
            value     = {10'd0, window.lead_byte[2:0], window.second_byte[5:0],
                         window.third_byte[5:0], window.fourth_byte[5:0]};
         end
         usd_pkg::LenFive: begin
            cont_ok   = &cont[4:1];
            min_value = usd_pkg::MinLenFive;
            value     = {5'd0, window.lead_byte[1:0], window.second_byte[5:0],
                         window.third_byte[5:0], window.fourth_byte[5:0],
                         window.fifth_byte[5:0]};
         end
         usd_pkg::LenSix: begin
            cont_ok   = &cont[5:1];
            min_value = usd_pkg::MinLenSix;
            value     = {window.lead_byte[0], window.second_byte[5:0],
                         window.third_byte[5:0], window.fourth_byte[5:0],
                         window.fifth_byte[5:0], window.sixth_byte[5:0]};
         end
         default: begin
            // single byte, or no valid lead
            cont_ok   = 1'b1;
            min_value = '0;
            value     = {24'd0, window.lead_byte[6:0]};
         end
      endcase
   end

   assign bad_value = (value < min_value)
                    || ((value >= usd_pkg::SurrogateLow) && (value <= usd_pkg::SurrogateHigh))
                    || (value == usd_pkg::NonCharFffe)
                    || (value == usd_pkg::NonCharFfff);

   always_comb begin
      priority if (seq_len == usd_pkg::LenInvalid || !cont_ok) begin
         result.code_point      = usd_pkg::ReplacementChar;
         result.consumed_length = usd_pkg::LenOne;
      end else if (seq_len == usd_pkg::LenOne) begin
         result.code_point      = value;
         result.consumed_length = usd_pkg::LenOne;
      end else begin
         result.code_point      = bad_value ? usd_pkg::ReplacementChar : value;
         result.consumed_length = seq_len;
      end
   end

endmodule

FILE: hdl/utf8_sequence_decoder_unit.sv
// Top level: registered UTF-8 sequence decoder with valid/ready channels.
//
// Usage
//   req_channel carries a six-byte window starting at a character boundary;
//   rsp_channel returns the code point (or FFFD when malformed) and how many
//   window bytes the sequence occupies, so the caller can advance its pointer.
//   A transaction happens on a rising edge with valid and ready both high.
// Timing: an accepted window is captured in the input register, then decoded
//   and loaded into the result register once that register is free or being
//   drained; the response is shown from the result register.
// Throughput: one transaction per cycle while rsp ready stays high; the decode
//   is a single pass of masking, concatenation and compares between the input
//   and result registers.
// Stall: when the receiver holds rsp ready low the result register holds its
//   transaction and the input register keeps one more; req ready falls only
//   once both are full. Up to two transactions are in flight.
// Reset: synchronous, active high; clears both valid flags, nothing else.
//   No state is carried between transactions.
`include "utf8_sequence_decoder_unit_defines.svh"

module utf8_sequence_decoder_unit (
   input  logic            clock,
   input  logic            reset,
   usd_req_if.sink         req_channel,
   usd_rsp_if.source       rsp_channel
);

   // input register stage
   logic                     in_valid_ff;
   logic                     in_valid_in;
   usd_pkg::req_payload_type in_data_ff;
   usd_pkg::req_payload_type in_data_in;
   usd_pkg::req_payload_type req_window;

   // result register stage
   logic                     out_valid_ff;
   logic                     out_valid_in;
   usd_pkg::rsp_payload_type out_data_ff;
   usd_pkg::rsp_payload_type out_data_in;
   usd_pkg::rsp_payload_type decoded;

   logic out_load;    // result register free or being drained
   logic req_accept;

   assign req_window = '{
      lead_byte:   req_channel.lead_byte,
      second_byte: req_channel.second_byte,
      third_byte:  req_channel.third_byte,
      fourth_byte: req_channel.fourth_byte,
      fifth_byte:  req_channel.fifth_byte,
      sixth_byte:  req_channel.sixth_byte
   };

   assign out_load          = !out_valid_ff || rsp_channel.ready;
   // input stage can take a new transaction when empty or moving on this cycle
   assign req_channel.ready = !in_valid_ff || out_load;
   assign req_accept        = req_channel.valid && req_channel.ready;

   usd_decode u_decode (
      .window (in_data_ff),
      .result (decoded)
   );

   always_comb begin
      in_valid_in = req_channel.ready ? req_channel.valid : in_valid_ff;
      in_data_in  = req_accept ? req_window : in_data_ff;
   end

   always_comb begin
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;
      out_data_in  = (out_load && in_valid_ff) ? decoded : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_channel.valid           = out_valid_ff;
   assign rsp_channel.code_point      = out_data_ff.code_point;
   assign rsp_channel.consumed_length = out_data_ff.consumed_length;

   // ---- checks ----
   // an accepted window always lands in the input register
   `USD_ASSERT_NEXT(a_accept_lands, clock, reset, req_accept, in_valid_ff)
   // a blocked result keeps a pending input transaction in place
   `USD_ASSERT_NEXT(a_hold_when_blocked, clock, reset, in_valid_ff && !out_load, in_valid_ff && out_valid_ff)
   // length is always one to six
   `USD_ASSERT_IMPLIES(a_length_range, clock, reset, out_valid_ff, out_data_ff.consumed_length != usd_pkg::LenInvalid && out_data_ff.consumed_length != 3'd7)
   // a one-byte result is ASCII or the replacement character
   `USD_ASSERT_IMPLIES(a_single_byte_value, clock, reset, out_valid_ff && out_data_ff.consumed_length == usd_pkg::LenOne, out_data_ff.code_point < 31'h80 || out_data_ff.code_point == usd_pkg::ReplacementChar)

endmodule

FILE: dv/utf8_sequence_decoder_unit_checker.sv
// Checker: predicts each decoded character and compares the response channel against it.
module utf8_sequence_decoder_unit_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  usd_pkg::req_payload_type req_window,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  usd_pkg::rsp_payload_type rsp_char,
   output int                       failures,
   output int                       pending_count,
   output int                       checked_count,
   output int                       replaced_count
);
   import usd_pkg::*;

   rsp_payload_type expected_chars[$];
   int              fail_total     = 0;
   int              pending_total  = 0;
   int              checked_total  = 0;
   int              replaced_total = 0;

   assign failures       = fail_total;
   assign pending_count  = pending_total;
   assign checked_count  = checked_total;
   assign replaced_count = replaced_total;

   // Decode one window exactly as the block should.
   function automatic rsp_payload_type decode_window(input req_payload_type w);
      logic [ByteWidth-1:0]      b [6];
      logic [LengthWidth-1:0]    seq_len;
      logic [CodePointWidth-1:0] value;
      logic [CodePointWidth-1:0] floor_value;
      logic                      well_formed;
      rsp_payload_type           r;
      int                        i;
      b[0] = w.lead_byte;
      b[1] = w.second_byte;
      b[2] = w.third_byte;
      b[3] = w.fourth_byte;
      b[4] = w.fifth_byte;
      b[5] = w.sixth_byte;
      if (b[0][7] == 1'b0)                 seq_len = LenOne;
      else if (b[0][7:6] == ContTag)       seq_len = LenInvalid;
      else if (b[0][7:5] == 3'b110)        seq_len = LenTwo;
      else if (b[0][7:4] == 4'b1110)       seq_len = LenThree;
      else if (b[0][7:3] == 5'b11110)      seq_len = LenFour;
      else if (b[0][7:2] == 6'b111110)     seq_len = LenFive;
      else if (b[0][7:1] == 7'b1111110)    seq_len = LenSix;
      else                                 seq_len = LenInvalid;

      r.code_point      = ReplacementChar;
      r.consumed_length = LenOne;
      if (seq_len == LenOne) begin
         r.code_point = {23'd0, b[0]};
      end else if (seq_len != LenInvalid) begin
         well_formed = 1'b1;
         for (i = 1; i < 6; i++)
            if (i < seq_len && b[i][7:6] != ContTag) well_formed = 1'b0;
         if (well_formed) begin
            value = {23'd0, b[0] & (8'hFF >> (seq_len + 3'd1))};
            for (i = 1; i < 6; i++)
               if (i < seq_len) value = (value << 6) | {25'd0, b[i][5:0]};
            case (seq_len)
               LenTwo:   floor_value = MinLenTwo;
               LenThree: floor_value = MinLenThree;
               LenFour:  floor_value = MinLenFour;
               LenFive:  floor_value = MinLenFive;
               default:  floor_value = MinLenSix;
            endcase
            if (value < floor_value || (value >= SurrogateLow && value <= SurrogateHigh) ||
                value == NonCharFffe || value == NonCharFfff)
               value = ReplacementChar;
            r.code_point      = value;
            r.consumed_length = seq_len;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch @%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_total++;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         // compare first, then queue the new window, so a stray response is never
         // matched against a window accepted at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("response with nothing outstanding, code_point",
                               {1'b0, rsp_char.code_point}, 32'd0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char.code_point !== want.code_point)
                  report_mismatch("code_point", {1'b0, rsp_char.code_point},
                                  {1'b0, want.code_point});
               if (rsp_char.consumed_length !== want.consumed_length)
                  report_mismatch("consumed_length", {29'd0, rsp_char.consumed_length},
                                  {29'd0, want.consumed_length});
               checked_total++;
               if (want.code_point == ReplacementChar) replaced_total++;
            end
         end
         if (req_valid && req_ready) expected_chars.push_back(decode_window(req_window));
      end
      pending_total = expected_chars.size();
   end

endmodule

FILE: dv/utf8_sequence_decoder_unit_tb.sv
// Testbench top: drives windows into the UTF-8 sequence decoder and gives the verdict.
module utf8_sequence_decoder_unit_tb;
   import usd_pkg::*;

   localparam int HalfPeriod     = 2;
   localparam int ResetCycles    = 8;
   localparam int RandomPerPhase = 460;   // three idle mixes, ~1400 windows in all
   localparam int DrainCycles    = 8;     // margin after the last response comes back
   localparam int WatchdogLimit  = 2000;  // cycles with no transaction on either side

   logic clock = 1'b0;
   logic reset = 1'b1;

   usd_req_if req_channel ();
   usd_rsp_if rsp_channel ();

   req_payload_type req_seen;
   rsp_payload_type rsp_seen;

   int  failures;
   int  pending_count;
   int  checked_count;
   int  replaced_count;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  stall_cycles  = 0;

   logic [47:0] directed_windows [25];

   always #HalfPeriod clock = ~clock;

   utf8_sequence_decoder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .rsp_channel (rsp_channel)
   );

   assign req_seen = {req_channel.lead_byte, req_channel.second_byte, req_channel.third_byte,
                      req_channel.fourth_byte, req_channel.fifth_byte, req_channel.sixth_byte};
   assign rsp_seen = {rsp_channel.code_point, rsp_channel.consumed_length};

   utf8_sequence_decoder_unit_checker char_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_channel.valid),
      .req_ready      (req_channel.ready),
      .req_window     (req_seen),
      .rsp_valid      (rsp_channel.valid),
      .rsp_ready      (rsp_channel.ready),
      .rsp_char       (rsp_seen),
      .failures       (failures),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .replaced_count (replaced_count)
   );

   // Receiver back-pressure: ready is redrawn on every falling edge, one
   // assignment per edge, so gaps land on every phase of the pipeline.
   always @(negedge clock) begin
      if (reset) begin
         rsp_channel.ready <= 1'b0;
      end else begin
         rsp_channel.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: a correct run never goes this long without a transaction.
   always @(posedge clock) begin
      if (reset || (req_channel.valid && req_channel.ready) ||
          (rsp_channel.valid && rsp_channel.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Build a random window. Some are well-formed sequences with random payload,
   // some are encodings of values around the range edges (overlong at times),
   // some have one continuation byte broken, the rest is plain noise.
   function automatic logic [47:0] random_window();
      logic [7:0]  win [6];
      logic [31:0] draw;
      logic [30:0] value;
      logic [1:0]  bad_tag;
      int          seq_len;
      int          min_len;
      int          pick;
      int          i;
      for (i = 0; i < 6; i++) win[i] = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 85) begin
         if (pick < 45) begin
            // any value that fits the chosen length, spread evenly
            seq_len = $urandom_range(1, 6);
            draw    = $urandom;
            value   = draw[30:0] >> (31 - ((seq_len == 1) ? 7 : 5 * seq_len + 1));
         end else begin
            case ($urandom_range(16))
               0:       value = 31'h0000_007F;
               1:       value = MinLenTwo;
               2:       value = 31'h0000_07FF;
               3:       value = MinLenThree;
               4:       value = 31'h0000_D7FF;
               5:       value = SurrogateLow;
               6:       value = SurrogateHigh;
               7:       value = 31'h0000_E000;
               8:       value = ReplacementChar;
               9:       value = NonCharFffe;
               10:      value = NonCharFfff;
               11:      value = MinLenFour;
               12:      value = 31'h001F_FFFF;
               13:      value = MinLenFive;
               14:      value = 31'h03FF_FFFF;
               15:      value = MinLenSix;
               default: value = 31'h7FFF_FFFF;
            endcase
            value = value + 31'($urandom_range(2)) - 31'd1;
            min_len = 1;
            while (min_len < 6 && (value >> ((min_len == 1) ? 7 : 5 * min_len + 1)) != 0)
               min_len++;
            // now and then stretch it into an overlong form
            seq_len = ($urandom_range(3) == 0) ? $urandom_range(min_len, 6) : min_len;
         end
         for (i = 5; i >= 1; i--) begin
            if (i < seq_len) begin
               win[i] = {2'b10, value[5:0]};
               value  = value >> 6;
            end
         end
         if (seq_len == 1) win[0] = {1'b0, value[6:0]};
         else              win[0] = (8'hFF << (8 - seq_len)) | value[7:0];
         if (pick >= 70 && seq_len > 1) begin
            case ($urandom_range(2))
               0:       bad_tag = 2'b00;
               1:       bad_tag = 2'b01;
               default: bad_tag = 2'b11;
            endcase
            i      = $urandom_range(1, seq_len - 1);
            win[i] = {bad_tag, 6'($urandom_range(63))};
         end
      end
      return {win[0], win[1], win[2], win[3], win[4], win[5]};
   endfunction

   // Offer one window and hold it until the decoder takes it. Returns on the
   // falling edge after the transaction, where the next call may keep valid up.
   task automatic send_window(input logic [47:0] win);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_channel.valid <= 1'b0;
         {req_channel.lead_byte, req_channel.second_byte, req_channel.third_byte,
          req_channel.fourth_byte, req_channel.fifth_byte, req_channel.sixth_byte}
            <= {$urandom, 16'($urandom)};
         @(negedge clock);
      end
      req_channel.valid <= 1'b1;
      {req_channel.lead_byte, req_channel.second_byte, req_channel.third_byte,
       req_channel.fourth_byte, req_channel.fifth_byte, req_channel.sixth_byte} <= win;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_channel.ready;
      end
      @(negedge clock);
   endtask

   initial begin
      int phase;
      int n;
      req_channel.valid       = 1'b0;
      req_channel.lead_byte   = '0;
      req_channel.second_byte = '0;
      req_channel.third_byte  = '0;
      req_channel.fourth_byte = '0;
      req_channel.fifth_byte  = '0;
      req_channel.sixth_byte  = '0;

      // Directed windows: range edges of every length, stray and invalid leads,
      // overlong forms, surrogates, the two noncharacters, missing continuations,
      // and junk past the end of the sequence.
      directed_windows = '{
         48'h00_FF_FF_FF_FF_FF,   // NUL, junk after it
         48'h7F_80_80_80_80_80,   // top of one byte
         48'h80_80_80_80_80_80,   // stray continuation as lead
         48'hFE_BF_BF_BF_BF_BF,   // invalid lead
         48'hFF_80_80_80_80_80,   // invalid lead
         48'hC0_80_00_00_00_00,   // overlong two-byte NUL
         48'hC2_80_FF_FF_FF_FF,   // lowest two-byte value
         48'hDF_BF_00_00_00_00,   // top of two bytes
         48'hC2_41_00_00_00_00,   // second byte not a continuation
         48'hE0_80_80_00_00_00,   // overlong three-byte
         48'hE0_A0_80_00_00_00,   // lowest three-byte value
         48'hED_A0_80_00_00_00,   // first surrogate
         48'hED_BF_BF_00_00_00,   // last surrogate
         48'hEF_BF_BE_00_00_00,   // noncharacter FFFE
         48'hEF_BF_BF_00_00_00,   // noncharacter FFFF
         48'hE2_82_C0_00_00_00,   // third byte broken
         48'hF0_80_80_80_00_00,   // overlong four-byte
         48'hF0_90_80_80_00_00,   // lowest four-byte value
         48'hF8_87_BF_BF_BF_00,   // overlong five-byte
         48'hF8_88_80_80_80_00,   // lowest five-byte value
         48'hFB_BF_BF_BF_BF_00,   // top of five bytes
         48'hFC_83_BF_BF_BF_BF,   // overlong six-byte
         48'hFC_84_80_80_80_80,   // lowest six-byte value
         48'hFD_BF_BF_BF_BF_BF,   // top of the 31-bit range
         48'hFD_BF_BF_BF_BF_7F    // last continuation missing
      };

      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Phase 0: sender rarely idles, receiver mostly stalls.
      // Phase 1: the other way round. Phase 2: both flat out.
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 86 : 0;
         recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 6 : 0;
         if (phase == 0)
            foreach (directed_windows[k]) send_window(directed_windows[k]);
         for (n = 0; n < RandomPerPhase; n++) send_window(random_window());
      end
      req_channel.valid <= 1'b0;

      // let everything in flight come back; the watchdog catches a hang
      while (pending_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("summary: %0d characters checked, %0d of them the replacement value",
               checked_count, replaced_count);
      $display("summary: directed edges plus random windows under three idle mixes");
      if (failures == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: utf8_sequence_decoder_unit.f
+incdir+hdl
hdl/usd_pkg.sv
hdl/usd_req_if.sv
hdl/usd_rsp_if.sv
hdl/usd_decode.sv
hdl/utf8_sequence_decoder_unit.sv
dv/utf8_sequence_decoder_unit_checker.sv
dv/utf8_sequence_decoder_unit_tb.sv
